// ----- sv/ibd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image box downscale package
// Beat types, register indexes and fixed field widths shared by the block.
// ----------------------------------------------------------------------------
package ibd_pkg;

    localparam int PIX_W       = 8;
    localparam int DST_SIDE_W  = 9;
    localparam int RATIO_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DST_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO    = 2'd1;

    localparam logic [DST_SIDE_W-1:0] DST_SIDE_RST = 9'd32;
    localparam logic [RATIO_W-1:0]    RATIO_RST    = 4'd2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] src_pixel;
        logic             frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] dst_pixel;
        logic             frame_last;
    } t_out_beat;

    // Control that travels alongside a block sum through the mean unit.
    typedef struct packed {
        logic vld;
        logic flast;
    } t_mean_tag;

endpackage

// ----- sv/ibd_sum_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block sum memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ibd_sum_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read happens before write on a same-address collision.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ibd_mean.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block mean unit
// Divides a block sum by ratio squared with a reciprocal multiply, saturating.
// ----------------------------------------------------------------------------
module ibd_mean #(
    parameter int MAX_RATIO = 8,
    parameter int SUM_W     = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  ibd_pkg::t_mean_tag           i_tag,
    input  logic [SUM_W-1:0]             i_sum,
    input  logic [$clog2(MAX_RATIO)-1:0] i_ratio_m1,
    output ibd_pkg::t_mean_tag           o_tag,
    output logic [ibd_pkg::PIX_W-1:0]    o_mean
);

    localparam int IDX_W = $clog2(MAX_RATIO);
    // Shift large enough that the rounded-up reciprocal is exact for every sum.
    localparam int SHIFT = SUM_W + 2 * IDX_W + 1;
    localparam int RCP_W = SHIFT + 1;
    localparam int PRD_W = SUM_W + RCP_W;
    localparam int QUO_W = PRD_W - SHIFT;

    logic [RCP_W-1:0] w_rcp [MAX_RATIO];

    for (genvar g = 1; g <= MAX_RATIO; g++) begin : g_rcp
        localparam longint unsigned DIV = longint'(g) * longint'(g);
        localparam longint unsigned RCP = ((64'd1 << SHIFT) + DIV - 64'd1) / DIV;
        assign w_rcp[g-1] = RCP_W'(RCP);
    end

    ibd_pkg::t_mean_tag r_tag_a;
    ibd_pkg::t_mean_tag r_tag_b;
    logic [SUM_W-1:0]   r_sum;
    logic [IDX_W-1:0]   r_idx;
    logic [PRD_W-1:0]   r_prod;
    logic [QUO_W-1:0]   w_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
        end else if (i_en) begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= i_sum;
            r_idx  <= i_ratio_m1;
            r_prod <= PRD_W'(r_sum) * PRD_W'(w_rcp[r_idx]);
        end
    end

    always_comb begin
        w_quo = r_prod[PRD_W-1:SHIFT];
        if (w_quo > QUO_W'(ibd_pkg::PIX_MAX)) begin
            o_mean = ibd_pkg::PIX_MAX;
        end else begin
            o_mean = w_quo[ibd_pkg::PIX_W-1:0];
        end
    end

    assign o_tag = r_tag_b;

endmodule

// ----- sv/image_box_downscale.sv -----
`timescale 1ns / 1ps
// Path: a result beat reaches o_valid once the input beat completing its block has passed
// the stage 1, mean unit and output registers; all of them hold while i_stall holds o_valid.
// Throughput: one input beat per clock unless the output is held; adjacent pixels never
// wait: the block sum read-modify-write forwards the last write past its registered read.
// Reset (synchronous, i_rst_n low): counters and pipeline valids clear, dst_side goes to 32
// and ratio to 2; the block sum memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Image box downscale
// Integer-ratio box filter that reduces a square grey image by averaging
// ratio-by-ratio source blocks, keeping one row of partial sums in a RAM.
// ----------------------------------------------------------------------------
module image_box_downscale #(
    parameter int MAX_SIDE  = 256,
    parameter int MAX_RATIO = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel input channel.
    input  logic                            i_valid,
    output logic                            o_stall,
    input  ibd_pkg::t_in_beat               i_beat,
    // Pixel output channel.
    output logic                            o_valid,
    input  logic                            i_stall,
    output ibd_pkg::t_out_beat              o_beat,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ibd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ibd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Widths that follow from the size limits.
    localparam int SC_W  = $clog2(MAX_RATIO);          // sub-block counters
    localparam int RW    = $clog2(MAX_RATIO + 1);      // effective ratio
    localparam int DW    = $clog2(MAX_SIDE);           // destination counters, RAM address
    localparam int SW    = $clog2(MAX_SIDE + 1);       // effective side
    localparam int SUM_W = $clog2(MAX_RATIO * MAX_RATIO * 255 + 1);

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are always taken; unknown indexes are
    // dropped.
    // ------------------------------------------------------------------------
    logic [ibd_pkg::DST_SIDE_W-1:0] r_dst_side;
    logic [ibd_pkg::RATIO_W-1:0]    r_ratio;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_side <= ibd_pkg::DST_SIDE_RST;
            r_ratio    <= ibd_pkg::RATIO_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ibd_pkg::REG_DST_SIDE: begin
                    r_dst_side <= i_cfg_data[ibd_pkg::DST_SIDE_W-1:0];
                end
                ibd_pkg::REG_RATIO: begin
                    r_ratio <= i_cfg_data[ibd_pkg::RATIO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Zero means one, and values past the build limits clamp to the limits.
    logic [RW-1:0] w_r;
    logic [RW-1:0] w_rm1;
    logic [SW-1:0] w_side;

    always_comb begin
        if (r_ratio == '0) begin
            w_r = RW'(1);
        end else if (int'(r_ratio) > MAX_RATIO) begin
            w_r = RW'(MAX_RATIO);
        end else begin
            w_r = RW'(r_ratio);
        end
        w_rm1 = w_r - RW'(1);

        if (r_dst_side == '0) begin
            w_side = SW'(1);
        end else if (int'(r_dst_side) > MAX_SIDE) begin
            w_side = SW'(MAX_SIDE);
        end else begin
            w_side = SW'(r_dst_side);
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline enable. Everything moves together; the only holdup is a result
    // sitting in the output register while the sink stalls.
    // ------------------------------------------------------------------------
    logic w_en;
    logic w_in_acc;
    logic r_out_vld;

    assign w_en     = !(r_out_vld && i_stall);
    assign o_stall  = !w_en;
    assign w_in_acc = i_valid && w_en;

    // ------------------------------------------------------------------------
    // Stage 0: position counters. A frame start forces every counter to zero
    // before the pixel is placed.
    // ------------------------------------------------------------------------
    logic [SC_W-1:0] r_sub_col, r_sub_row;
    logic [DW-1:0]   r_dst_col, r_dst_row;
    logic [SC_W-1:0] n_sub_col, n_sub_row;
    logic [DW-1:0]   n_dst_col, n_dst_row;
    logic [SC_W-1:0] w_sc, w_sr;
    logic [DW-1:0]   w_dc, w_dr;
    logic            w_first;
    logic            w_emit;
    logic            w_flast;

    always_comb begin
        if (i_beat.frame_start) begin
            w_sc = '0;
            w_sr = '0;
            w_dc = '0;
            w_dr = '0;
        end else begin
            w_sc = r_sub_col;
            w_sr = r_sub_row;
            w_dc = r_dst_col;
            w_dr = r_dst_row;
        end

        // The first pixel of a block overwrites its sum entry.
        w_first = (w_sc == '0) && (w_sr == '0);
        // The last pixel of a block completes it.
        w_emit  = (int'(w_sc) == int'(w_rm1)) && (int'(w_sr) == int'(w_rm1));
        w_flast = (int'(w_dc) == int'(w_side) - 1) && (int'(w_dr) == int'(w_side) - 1);

        // Raster advance. A counter left above a lowered limit wraps at its
        // next step.
        n_sub_col = w_sc;
        n_sub_row = w_sr;
        n_dst_col = w_dc;
        n_dst_row = w_dr;
        if (int'(w_sc) + 1 >= int'(w_r)) begin
            n_sub_col = '0;
            if (int'(w_dc) + 1 >= int'(w_side)) begin
                n_dst_col = '0;
                if (int'(w_sr) + 1 >= int'(w_r)) begin
                    n_sub_row = '0;
                    if (int'(w_dr) + 1 >= int'(w_side)) begin
                        n_dst_row = '0;
                    end else begin
                        n_dst_row = w_dr + DW'(1);
                    end
                end else begin
                    n_sub_row = w_sr + SC_W'(1);
                end
            end else begin
                n_dst_col = w_dc + DW'(1);
            end
        end else begin
            n_sub_col = w_sc + SC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_col <= '0;
            r_sub_row <= '0;
            r_dst_col <= '0;
            r_dst_row <= '0;
        end else if (w_in_acc) begin
            r_sub_col <= n_sub_col;
            r_sub_row <= n_sub_row;
            r_dst_col <= n_dst_col;
            r_dst_row <= n_dst_row;
        end
    end

    // Stage 1 registers: the pixel waits here for its sum entry to be read.
    logic                      r_s1_vld;
    logic [DW-1:0]             r_s1_addr;
    logic [ibd_pkg::PIX_W-1:0] r_s1_pix;
    logic                      r_s1_first;
    logic                      r_s1_emit;
    logic                      r_s1_flast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_addr  <= w_dc;
            r_s1_pix   <= i_beat.src_pixel;
            r_s1_first <= w_first;
            r_s1_emit  <= w_emit;
            r_s1_flast <= w_flast;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: accumulate into the sum row. A pixel that follows one of the
    // same block column reads the RAM before that write lands, so the last
    // written sum is forwarded when the addresses match.
    // ------------------------------------------------------------------------
    logic [SUM_W-1:0] w_rdata;
    logic [SUM_W-1:0] w_base;
    logic [SUM_W-1:0] w_acc;
    logic             w_we;
    logic             r_last_vld;
    logic [DW-1:0]    r_last_addr;
    logic [SUM_W-1:0] r_last_acc;

    ibd_sum_ram #(
        .DEPTH (MAX_SIDE),
        .WIDTH (SUM_W)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s1_addr),
        .i_wdata (w_acc),
        .i_re    (w_en),
        .i_raddr (w_dc),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_last_vld && (r_last_addr == r_s1_addr)) begin
            w_base = r_last_acc;
        end else begin
            w_base = w_rdata;
        end
        if (r_s1_first) begin
            w_acc = SUM_W'(r_s1_pix);
        end else begin
            w_acc = w_base + SUM_W'(r_s1_pix);
        end
    end

    assign w_we = w_en && r_s1_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_vld <= 1'b0;
        end else if (w_we) begin
            r_last_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_last_addr <= r_s1_addr;
            r_last_acc  <= w_acc;
        end
    end

    // ------------------------------------------------------------------------
    // Stages 2 and 3: completed block sums go through the mean unit.
    // ------------------------------------------------------------------------
    ibd_pkg::t_mean_tag        w_mean_in_tag;
    ibd_pkg::t_mean_tag        w_mean_tag;
    logic [ibd_pkg::PIX_W-1:0] w_mean;

    assign w_mean_in_tag.vld   = r_s1_vld && r_s1_emit;
    assign w_mean_in_tag.flast = r_s1_flast;

    ibd_mean #(
        .MAX_RATIO (MAX_RATIO),
        .SUM_W     (SUM_W)
    ) u_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_tag      (w_mean_in_tag),
        .i_sum      (w_acc),
        .i_ratio_m1 (w_rm1[SC_W-1:0]),
        .o_tag      (w_mean_tag),
        .o_mean     (w_mean)
    );

    // ------------------------------------------------------------------------
    // Output register. It is refilled in the same cycle its beat is taken.
    // ------------------------------------------------------------------------
    ibd_pkg::t_out_beat r_out_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_mean_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_beat.dst_pixel  <= w_mean;
            r_out_beat.frame_last <= w_mean_tag.flast;
        end
    end

    assign o_valid = r_out_vld;
    assign o_beat  = r_out_beat;

`ifndef NO_ASSERTIONS
    // A frame start always restarts a block, so its sum entry is overwritten.
    a_frame_start_first : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_beat.frame_start |=> r_s1_vld && r_s1_first)
        else $error("frame start did not open a new block");

    // The sum row is never written while the pipeline is held.
    a_no_write_on_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> !w_we)
        else $error("sum memory written while pipeline held");

    // A completed block that moves on reaches the mean unit.
    a_emit_enters_mean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_s1_vld && r_s1_emit |=> $past(w_mean_in_tag.vld))
        else $error("completed block lost before the mean unit");

    // A held result keeps the whole pipeline and the counters still.
    a_hold_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |=> $stable(r_dst_col) && $stable(r_s1_vld))
        else $error("pipeline moved while the output was held");
`endif

endmodule

// ----- tb/tb_image_box_downscale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image box downscale testbench
// Drives grey pixel beats through the box-filter downscaler under changing
// sizes and ratios, predicts or types in every block mean and end-of-frame
// flag, and compares each output beat with the expectation in order of arrival.
// ----------------------------------------------------------------------------
module tb_image_box_downscale;

    localparam int MAX_SIDE  = 256;
    localparam int MAX_RATIO = 8;

    // Run length controls.
    localparam int RANDOM_PIXELS = 450;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 200000;

    // Index that selects no register; writes to it must be ignored.
    localparam logic [ibd_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    // ------------------------------------------------------------------------
    // Clock, reset and the block under test
    // ------------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    ibd_pkg::t_in_beat              i_beat;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    ibd_pkg::t_out_beat             o_beat;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [ibd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [ibd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    image_box_downscale #(
        .MAX_SIDE  (MAX_SIDE),
        .MAX_RATIO (MAX_RATIO)
    ) dut (.*);

    // ------------------------------------------------------------------------
    // Box filter predictor: its own copy of the registers, the row of partial
    // block sums and the four position counters.
    // ------------------------------------------------------------------------
    logic [ibd_pkg::DST_SIDE_W-1:0] cfg_side;
    logic [ibd_pkg::RATIO_W-1:0]    cfg_ratio;
    int unsigned                    row_sums [0:MAX_SIDE-1];
    int unsigned                    sub_col, dst_col, sub_row, dst_row;

    // Out-of-range register values are clamped, never rejected.
    function automatic int unsigned eff_ratio(input logic [ibd_pkg::RATIO_W-1:0] r);
        if (r == '0) return 1;
        if (32'(r) > MAX_RATIO) return MAX_RATIO;
        return 32'(r);
    endfunction

    function automatic int unsigned eff_side(input logic [ibd_pkg::DST_SIDE_W-1:0] s);
        if (s == '0) return 1;
        if (32'(s) > MAX_SIDE) return MAX_SIDE;
        return 32'(s);
    endfunction

    // Advances the predictor by one accepted pixel. Returns 1 and fills mean
    // when this pixel completes a block.
    function automatic bit box_mean_step(input ibd_pkg::t_in_beat px,
                                         output ibd_pkg::t_out_beat mean);
        int unsigned r;
        int unsigned side;
        int unsigned col;
        int unsigned acc;
        int unsigned avg;
        bit          done;
        r    = eff_ratio(cfg_ratio);
        side = eff_side(cfg_side);
        done = 1'b0;
        mean = '0;
        if (px.frame_start) begin
            sub_col = 0;
            dst_col = 0;
            sub_row = 0;
            dst_row = 0;
        end
        col = (dst_col < MAX_SIDE) ? dst_col : 0;
        // The first pixel of a block overwrites the stale entry.
        if (sub_row == 0 && sub_col == 0)
            acc = 32'(px.src_pixel);
        else
            acc = row_sums[col] + 32'(px.src_pixel);
        row_sums[col] = acc;
        if (sub_row == r - 1 && sub_col == r - 1) begin
            avg = acc / (r * r);
            // Only a ratio change inside a block can push the mean past 255.
            if (avg > 255) avg = 255;
            mean.dst_pixel  = avg[ibd_pkg::PIX_W-1:0];
            mean.frame_last = (dst_col == side - 1 && dst_row == side - 1);
            done = 1'b1;
        end
        // A counter left above a shrunken limit wraps at its next advance.
        sub_col++;
        if (sub_col >= r) begin
            sub_col = 0;
            dst_col++;
            if (dst_col >= side) begin
                dst_col = 0;
                sub_row++;
                if (sub_row >= r) begin
                    sub_row = 0;
                    dst_row++;
                    if (dst_row >= side) dst_row = 0;
                end
            end
        end
        return done;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard. Expected means wait here in pixel order; each output beat
    // is checked against the oldest one.
    // ------------------------------------------------------------------------
    ibd_pkg::t_out_beat pending_means [$];
    int unsigned        mismatches    = 0;
    int unsigned        means_checked = 0;
    int unsigned        cycle_count   = 0;
    int unsigned        input_stalls  = 0;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Everything is driven on the rising edge, so the falling edge sees
    // settled values; a beat seen here with stall low is taken at the next edge.
    always @(negedge i_clk) begin
        ibd_pkg::t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_means.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat, pixel %0d last %0b",
                                        o_beat.dst_pixel, o_beat.frame_last));
            end else begin
                want = pending_means.pop_front();
                if (o_beat.dst_pixel !== want.dst_pixel)
                    flag_mismatch($sformatf("dst_pixel %0d, expected %0d",
                                            o_beat.dst_pixel, want.dst_pixel));
                if (o_beat.frame_last !== want.frame_last)
                    flag_mismatch($sformatf("frame_last %0b, expected %0b",
                                            o_beat.frame_last, want.frame_last));
                means_checked++;
            end
        end
        if (i_rst_n && i_valid && o_stall) input_stalls++;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d means still pending",
                     cycle_count, pending_means.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It stalls at random in the share set by the stimulus, and
    // once holds off for a long stretch so that the block backs up.
    // ------------------------------------------------------------------------
    int unsigned recv_idle_pct = 0;
    int unsigned send_idle_pct = 0;
    bit          hold_go       = 1'b0;
    bit          hold_on       = 1'b0;

    always @(posedge i_clk)
        i_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offers one pixel beat and returns once it is taken and any idle gap ends.
    // Typed rows queue their written-in mean; others queue any predicted mean.
    task automatic send_pixel(input ibd_pkg::t_in_beat px, input bit typed,
                              input ibd_pkg::t_out_beat typed_mean);
        ibd_pkg::t_out_beat mean;
        bit                 done;
        done = box_mean_step(px, mean);
        if (typed)
            pending_means = {pending_means, typed_mean};
        else if (done)
            pending_means = {pending_means, mean};
        i_valid <= 1'b1;
        i_beat  <= px;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Waits until every expected mean has arrived, then lets the pipeline
    // empty of beats that produce nothing.
    task automatic drain_block();
        i_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ibd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ibd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == ibd_pkg::REG_DST_SIDE)
            cfg_side = data;
        else if (idx == ibd_pkg::REG_RATIO)
            cfg_ratio = data[ibd_pkg::RATIO_W-1:0];
    endtask

    // ------------------------------------------------------------------------
    // Directed script: register writes and pixels in one table. Means that
    // are obvious by inspection are typed in; the rest come from the predictor.
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_TYPED} t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [ibd_pkg::CFG_IDX_W-1:0]  idx;
        logic [ibd_pkg::CFG_DATA_W-1:0] data;
        ibd_pkg::t_in_beat              px;
        ibd_pkg::t_out_beat             mean;
    } t_script_row;

    t_script_row script [$];

    function automatic void cfg_row(input logic [ibd_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [ibd_pkg::CFG_DATA_W-1:0] data);
        t_script_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        script   = {script, row};
    endfunction

    function automatic void pix_row(input logic [ibd_pkg::PIX_W-1:0] pix, input logic fs);
        t_script_row row;
        row                = '0;
        row.kind           = ROW_PIX;
        row.px.src_pixel   = pix;
        row.px.frame_start = fs;
        script             = {script, row};
    endfunction

    function automatic void typed_row(input logic [ibd_pkg::PIX_W-1:0] pix, input logic fs,
                                      input logic [ibd_pkg::PIX_W-1:0] want,
                                      input logic last);
        t_script_row row;
        row                 = '0;
        row.kind            = ROW_TYPED;
        row.px.src_pixel    = pix;
        row.px.frame_start  = fs;
        row.mean.dst_pixel  = want;
        row.mean.frame_last = last;
        script              = {script, row};
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        ibd_pkg::t_in_beat              px;
        int unsigned                    rand_pixels;
        int unsigned                    phase;
        int unsigned                    frame_len;
        int unsigned                    count;
        int unsigned                    sel;
        int unsigned                    directed_pixels;
        logic [ibd_pkg::DST_SIDE_W-1:0] side;
        logic [ibd_pkg::RATIO_W-1:0]    ratio;
        ibd_pkg::t_out_beat             dummy;

        rand_pixels     = 0;
        phase           = 0;
        directed_pixels = 0;
        dummy           = '0;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_beat      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= ibd_pkg::REG_DST_SIDE;
        i_cfg_data  <= '0;

        cfg_side  = ibd_pkg::DST_SIDE_RST;
        cfg_ratio = ibd_pkg::RATIO_RST;
        sub_col   = 0;
        dst_col   = 0;
        sub_row   = 0;
        dst_row   = 0;
        foreach (row_sums[k]) row_sums[k] = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Both sizes clamped up from zero: every pixel is a whole frame.
        cfg_row(ibd_pkg::REG_DST_SIDE, 9'd0);
        cfg_row(ibd_pkg::REG_RATIO, 9'd0);
        typed_row(8'h00, 1'b1, 8'h00, 1'b1);
        typed_row(8'hFF, 1'b0, 8'hFF, 1'b1);
        typed_row(8'hA5, 1'b1, 8'hA5, 1'b1);
        // Side above the maximum is clamped; the upper data bits of the
        // ratio write are not part of the register.
        cfg_row(ibd_pkg::REG_DST_SIDE, 9'h1FF);
        cfg_row(ibd_pkg::REG_RATIO, 9'h1F1);
        typed_row(8'hFF, 1'b1, 8'hFF, 1'b0);
        typed_row(8'h00, 1'b0, 8'h00, 1'b0);
        typed_row(8'h5A, 1'b0, 8'h5A, 1'b0);
        // A write to an unused index changes nothing.
        cfg_row(REG_NONE, 9'h1FF);
        // A 2x2 copy, then a fifth pixel that opens the next frame without
        // frame_start because the counters wrapped.
        cfg_row(ibd_pkg::REG_DST_SIDE, 9'd2);
        typed_row(8'h10, 1'b1, 8'h10, 1'b0);
        typed_row(8'h20, 1'b0, 8'h20, 1'b0);
        typed_row(8'h30, 1'b0, 8'h30, 1'b0);
        typed_row(8'h40, 1'b0, 8'h40, 1'b1);
        typed_row(8'h50, 1'b0, 8'h50, 1'b0);
        // 2x2 blocks: the mean truncates, and a full block of 255 stays 255.
        cfg_row(ibd_pkg::REG_DST_SIDE, 9'd1);
        cfg_row(ibd_pkg::REG_RATIO, 9'd2);
        pix_row(8'h00, 1'b1);
        pix_row(8'h00, 1'b0);
        pix_row(8'h00, 1'b0);
        typed_row(8'h03, 1'b0, 8'h00, 1'b1);
        pix_row(8'hFF, 1'b0);
        pix_row(8'hFF, 1'b0);
        pix_row(8'hFF, 1'b0);
        typed_row(8'hFF, 1'b0, 8'hFF, 1'b1);
        // Ratio shrinks from 3 to 2 inside a block: five pixels of 255 over
        // four saturate the mean.
        cfg_row(ibd_pkg::REG_RATIO, 9'd3);
        pix_row(8'hFF, 1'b1);
        pix_row(8'hFF, 1'b0);
        pix_row(8'hFF, 1'b0);
        pix_row(8'hFF, 1'b0);
        cfg_row(ibd_pkg::REG_RATIO, 9'd2);
        typed_row(8'hFF, 1'b0, 8'hFF, 1'b1);

        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG) begin
                drain_block();
                write_reg(script[k].idx, script[k].data);
            end else begin
                send_pixel(script[k].px, script[k].kind == ROW_TYPED, script[k].mean);
                directed_pixels++;
            end
        end

        // Random part. Each phase picks sizes, then sends whole frames with
        // random content; frames too big for the budget are cut short by the
        // next phase's frame_start. A few stray frame_starts break frames.
        while (rand_pixels < RANDOM_PIXELS) begin
            phase++;
            if (rand_pixels < RANDOM_PIXELS / 3) begin
                send_idle_pct <= 28;
                recv_idle_pct <= 58;
            end else if (rand_pixels < 2 * RANDOM_PIXELS / 3) begin
                send_idle_pct <= 58;
                recv_idle_pct <= 28;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end

            case (phase)
                1: begin
                    // One mean per pixel while the receiver holds off.
                    side  = 9'd4;
                    ratio = 4'd1;
                end
                2: begin
                    side  = 9'd1;
                    ratio = 4'd15;
                end
                3: begin
                    side  = 9'd256;
                    ratio = 4'd8;
                end
                default: begin
                    sel = $urandom_range(19);
                    if (sel == 0)
                        side = 9'd0;
                    else if (sel == 1)
                        side = 9'($urandom_range(255, 511));
                    else
                        side = 9'($urandom_range(1, 4));
                    ratio = 4'($urandom_range(0, 15));
                end
            endcase

            drain_block();
            write_reg(ibd_pkg::REG_DST_SIDE, side);
            write_reg(ibd_pkg::REG_RATIO, {5'($urandom_range(0, 31)), ratio});

            frame_len = eff_side(side) * eff_ratio(ratio);
            frame_len = frame_len * frame_len;
            if (phase == 1)
                count = 3 * frame_len;
            else if (frame_len > 240)
                count = $urandom_range(30, 90);
            else
                count = frame_len * $urandom_range(1, 3);

            if (phase == 1) hold_go = 1'b1;

            for (int unsigned n = 0; n < count && rand_pixels < RANDOM_PIXELS; n++) begin
                sel = $urandom_range(9);
                if (sel == 0)
                    px.src_pixel = 8'h00;
                else if (sel == 1)
                    px.src_pixel = ibd_pkg::PIX_MAX;
                else
                    px.src_pixel = 8'($urandom_range(0, 255));
                px.frame_start = (n == 0)
                              || (n % frame_len == 0 && $urandom_range(1) == 1)
                              || ($urandom_range(99) < 3);
                send_pixel(px, 1'b0, dummy);
                rand_pixels++;
            end
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_means.size() != 0)
            flag_mismatch($sformatf("%0d expected means never arrived", pending_means.size()));

        $display("covered %0d directed and %0d random pixel beats over %0d size settings",
                 directed_pixels, rand_pixels, phase);
        $display("checked %0d output beats; input held by the block on %0d cycles",
                 means_checked, input_stalls);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
